// File: src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser, the output register and the top level; no dependencies.
package wsd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_DROP = 3'd5
  } phase_t;

  // Frame kinds taken from header byte 0
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_PONG  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LONG  = 2'd2,
    ST_WIDE  = 2'd3
  } status_t;

  localparam logic [7:0]  HDR_TEXT      = 8'h81;
  localparam logic [7:0]  HDR_PONG      = 8'h8A;
  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [1:0]  KEY_LAST      = 2'd3;
  localparam logic [15:0] MAX_PAY_RESET = 16'd1024;

  // One result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_payload;
    kind_t      frame_kind;
    status_t    status;
  } result_t;

endpackage

// File: src/wsd_parser.sv
// Frame header parser and payload unmasker: holds the parse state and the
// max_payload register, and turns one byte into at most one result.
// Depends on wsd_pkg.
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             frame_start,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  logic [15:0] max_payload;
  phase_t      phase, phase_next;
  kind_t       kind_seen, kind_seen_next;
  logic        mask_present, mask_present_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] length_left, length_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_position, key_position_next;

  logic [15:0] len_new;
  logic [15:0] len_dec;
  logic [7:0]  key_byte;
  logic [6:0]  marker;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAY_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_data;
    end
  end

  // Parse state, advanced once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      kind_seen    <= KIND_OTHER;
      mask_present <= 1'b0;
      header_count <= 2'd0;
      length_left  <= 16'd0;
      mask_key     <= 32'd0;
      key_position <= 2'd0;
    end else if (step) begin
      phase        <= phase_next;
      kind_seen    <= kind_seen_next;
      mask_present <= mask_present_next;
      header_count <= header_count_next;
      length_left  <= length_left_next;
      mask_key     <= mask_key_next;
      key_position <= key_position_next;
    end
  end

  // Select the key byte for this payload position
  always_comb begin
    unique case (key_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign marker  = in_byte[6:0];
  assign len_dec = length_left - 16'd1;

  // Next state and result
  always_comb begin
    phase_next        = phase;
    kind_seen_next    = kind_seen;
    mask_present_next = mask_present;
    header_count_next = header_count;
    length_left_next  = length_left;
    mask_key_next     = mask_key;
    key_position_next = key_position;
    len_new           = 16'd0;
    res_valid         = 1'b0;
    res.data_byte       = 8'd0;
    res.last_of_payload = 1'b1;
    res.frame_kind      = kind_seen;
    res.status          = ST_DATA;

    if (frame_start) begin
      // Restart on a frame start byte, whatever the phase
      if (in_byte == HDR_TEXT) begin
        kind_seen_next = KIND_TEXT;
      end else if (in_byte == HDR_PONG) begin
        kind_seen_next = KIND_PONG;
      end else begin
        kind_seen_next = KIND_OTHER;
      end
      mask_present_next = 1'b0;
      header_count_next = 2'd0;
      length_left_next  = 16'd0;
      mask_key_next     = 32'd0;
      key_position_next = 2'd0;
      phase_next        = PH_LEN;
    end else begin
      unique case (phase)
        PH_LEN, PH_EXT: begin
          // Length byte, or an extended length byte
          if (phase == PH_LEN) begin
            mask_present_next = in_byte[7];
            len_new = {9'd0, marker};
          end else begin
            len_new = {length_left[15:8], in_byte};
          end
          if (phase == PH_LEN && marker > LEN_EXT16) begin
            phase_next    = PH_DROP;
            res_valid     = 1'b1;
            res.status    = ST_WIDE;
          end else if (phase == PH_LEN && marker == LEN_EXT16) begin
            header_count_next = 2'd0;
            phase_next        = PH_EXT;
          end else if (phase == PH_EXT && header_count == 2'd0) begin
            length_left_next  = {in_byte, 8'd0};
            header_count_next = 2'd1;
          end else begin
            length_left_next = len_new;
            if (len_new > max_payload) begin
              phase_next = PH_DROP;
              res_valid  = 1'b1;
              res.status = ST_LONG;
            end else if ((phase == PH_LEN) ? in_byte[7] : mask_present) begin
              header_count_next = 2'd0;
              phase_next        = PH_KEY;
            end else if (len_new == 16'd0) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              key_position_next = 2'd0;
              phase_next        = PH_DATA;
            end
          end
        end
        PH_KEY: begin
          // Shift in key bytes, first byte ends up in the top
          mask_key_next = {mask_key[23:0], in_byte};
          if (header_count != KEY_LAST) begin
            header_count_next = header_count + 2'd1;
          end else begin
            header_count_next = 2'd0;
            if (length_left == 16'd0) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              key_position_next = 2'd0;
              phase_next        = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          // Unmask and emit a payload byte
          key_position_next   = key_position + 2'd1;
          length_left_next    = len_dec;
          res_valid           = 1'b1;
          res.data_byte       = in_byte ^ key_byte;
          res.last_of_payload = (len_dec == 16'd0);
          if (len_dec == 16'd0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // Idle or dropping: ignore stray bytes
        end
      endcase
    end
  end

endmodule

// File: src/wsd_out_reg.sv
// Result register of the deframer: holds one result beat until taken.
// Depends on wsd_pkg.
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             busy,
  output logic [7:0]       data_byte,
  output logic             last_of_payload,
  output logic [1:0]       frame_kind,
  output logic [1:0]       status
);
  import wsd_pkg::*;

  result_t held;

  // Valid flag: set on load, clear when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign busy            = out_valid && out_stall;
  assign data_byte       = held.data_byte;
  assign last_of_payload = held.last_of_payload;
  assign frame_kind      = held.frame_kind;
  assign status          = held.status;

endmodule

// File: src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser and
// result register. Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one received byte per beat,
//   with frame_start set on byte 0 of each frame. Output channel
//   (out_valid/out_stall) carries one result per payload byte, plus one
//   status result for an empty, too long or 64-bit length frame. Header
//   bytes give no result.
//   The config channel (cfg_valid/cfg_ready, cfg_data) writes max_payload;
//   cfg_ready is always high. Write it only while no frame is in flight.
//   Path: a taken byte is held in the input register, parsed, and its result
//   is registered in the result register.
//   Throughput: one byte per cycle while the receiver does not stall, with
//   a combinational parse between the input register and the result register.
//   When the receiver stalls with a result held, the parser stops and
//   in_stall rises once the input register is also full.
//   Reset (rst, synchronous) empties both registers, sets max_payload to
//   1024 and returns the parser to waiting for a frame start.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        last_of_payload,
  output logic [1:0]  frame_kind,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import wsd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       step;
  logic       busy;
  logic       res_valid;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid && !busy;
  assign in_stall  = s1_valid && busy;

  // Input register: advance whenever the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte  <= in_byte;
      s1_start <= frame_start;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .step        (step),
    .in_byte     (s1_byte),
    .frame_start (s1_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (step && res_valid),
    .res             (res),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .busy            (busy),
    .data_byte       (data_byte),
    .last_of_payload (last_of_payload),
    .frame_kind      (frame_kind),
    .status          (status)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DATA) |-> (data_byte == 8'd0))
    else $error("status result carries data");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DATA) |-> last_of_payload)
    else $error("status result not marked last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("registers not empty after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_kind != 2'd3))
    else $error("bad frame kind");
`endif

endmodule
